FILE: sv/frame_vertex_rotator_core_assert.svh
// assertion macros shared by the frame vertex rotator modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef FRAME_VERTEX_ROTATOR_CORE_ASSERT_SVH
`define FRAME_VERTEX_ROTATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define FVR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fvr assertion failed");
// check a property on every clock edge, reset included
`define FVR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("fvr assertion failed");
`else
`define FVR_ASSERT(lbl, prop)
`define FVR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: sv/fvr_pkg.sv
// shared constants, types and the sine/cosine table of the vertex rotator
// no dependencies; the table is built at elaboration by integer series sums
package fvr_pkg;

  localparam int TrigFracBits   = 14;
  localparam int TrigWidth      = TrigFracBits + 2;
  localparam int DegreesPerTurn = 360;
  localparam int AngleWidth     = $clog2(DegreesPerTurn);
  localparam int CoordWidth     = 16;
  localparam int ProdWidth      = CoordWidth + TrigWidth;
  localparam int SumWidth       = ProdWidth + 1;
  localparam int ShiftWidth     = SumWidth - TrigFracBits;

  // theta = degrees * 3.1416 / 180 = degrees * PiNum / PiDen
  localparam longint unsigned PiNum   = 64'd3927;
  localparam longint unsigned PiDen   = 64'd225000;
  localparam int              SerFrac = 32;
  localparam int              SerTerms = 100;

  typedef logic signed [TrigWidth-1:0] trig_t;
  typedef logic [DegreesPerTurn-1:0][TrigWidth-1:0] trig_tab_t;
  typedef logic signed [CoordWidth-1:0] coord_t;

  // round a Q32 value to the trig format, ties away from zero
  function automatic trig_t to_trig_q(input longint signed v);
    longint unsigned m;
    longint unsigned r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = (m + (64'd1 << (SerFrac - TrigFracBits - 1))) >> (SerFrac - TrigFracBits);
    return (v < 0) ? trig_t'(-r) : trig_t'(r);
  endfunction

  // unsigned long division, only used while the table is built
  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // taylor series of sine or cosine for every whole degree
  function automatic trig_tab_t build_trig_tab(input logic want_cos);
    trig_tab_t         tab;
    longint unsigned   mul;
    longint unsigned   term;
    longint unsigned   sp;
    longint unsigned   sn;
    longint unsigned   cp;
    longint unsigned   cn;
    longint signed     v;
    for (int d = 0; d < DegreesPerTurn; d++) begin
      mul  = longint'(d) * PiNum;
      term = 64'd1 << SerFrac;
      sp   = 64'd0;
      sn   = 64'd0;
      cp   = term;
      cn   = 64'd0;
      for (int n = 1; n < SerTerms && term != 64'd0; n++) begin
        term = long_div(term * mul, PiDen);
        term = long_div(term, longint'(n));
        case (n[1:0])
          2'd0:    cp = cp + term;
          2'd1:    sp = sp + term;
          2'd2:    cn = cn + term;
          default: sn = sn + term;
        endcase
      end
      if (want_cos) begin
        v = longint'(cp) - longint'(cn);
      end else begin
        v = longint'(sp) - longint'(sn);
      end
      tab[d] = to_trig_q(v);
    end
    return tab;
  endfunction

  localparam trig_tab_t SinTab = build_trig_tab(1'b0);
  localparam trig_tab_t CosTab = build_trig_tab(1'b1);

endpackage

FILE: sv/frame_vertex_rotator_core.sv
// top level of the frame vertex rotator: input stage, rotation, result stage
// depends on fvr_pkg, fvr_angle, fvr_rot_math and the assertion macro header
//
//   channel  dir  handshake              word
//   in       in   in_valid_i/in_stall_o  x_in_i y_in_i z_in_i frame_end_i
//   out      out  out_valid_o/out_stall_i x_out_o y_out_o z_out_o frame_end_out_o
//
// one word per cycle while the result side does not stall; a taken word is offered from the result register
// the input register holds the word with the sine and cosine of the current angle,
// the result register then takes the rounded products
// reset clears the valid flags of both stages and sets the angle to zero degrees
// a stall on the result side reaches in_stall_o only once both stages hold a word
`include "frame_vertex_rotator_core_assert.svh"

module frame_vertex_rotator_core
  import fvr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  coord_t x_in_i,
  input  coord_t y_in_i,
  input  coord_t z_in_i,
  input  logic   frame_end_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output coord_t x_out_o,
  output coord_t y_out_o,
  output coord_t z_out_o,
  output logic   frame_end_out_o
);

  logic   s1_valid_q;
  coord_t s1_x_q;
  coord_t s1_y_q;
  coord_t s1_z_q;
  logic   s1_fe_q;
  trig_t  s1_cos_q;
  trig_t  s1_sin_q;

  logic   out_valid_q;
  coord_t out_x_q;
  coord_t out_y_q;
  coord_t out_z_q;
  logic   out_fe_q;

  logic   out_adv;
  logic   s1_adv;
  logic   in_accept;
  trig_t  cur_cos;
  trig_t  cur_sin;
  coord_t x_rot;
  coord_t y_rot;

  // stage flow control
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign in_accept  = in_valid_i && s1_adv;

  // angle advances after the last word of a frame has taken its sine and cosine
  fvr_angle u_angle (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept && frame_end_i),
    .cos_o     (cur_cos),
    .sin_o     (cur_sin)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_x_q   <= x_in_i;
      s1_y_q   <= y_in_i;
      s1_z_q   <= z_in_i;
      s1_fe_q  <= frame_end_i;
      s1_cos_q <= cur_cos;
      s1_sin_q <= cur_sin;
    end
  end

  fvr_rot_math u_rot_math (
    .x_i     (s1_x_q),
    .y_i     (s1_y_q),
    .cos_i   (s1_cos_q),
    .sin_i   (s1_sin_q),
    .x_rot_o (x_rot),
    .y_rot_o (y_rot)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_x_q  <= x_rot;
      out_y_q  <= y_rot;
      out_z_q  <= s1_z_q;
      out_fe_q <= s1_fe_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign x_out_o         = out_x_q;
  assign y_out_o         = out_y_q;
  assign z_out_o         = out_z_q;
  assign frame_end_out_o = out_fe_q;

  `FVR_ASSERT(a_accept_fills_s1, in_accept |=> s1_valid_q)
  `FVR_ASSERT(a_s1_kept_on_block, s1_valid_q && !out_adv |=> s1_valid_q && $stable(s1_x_q))
  `FVR_ASSERT(a_s1_moves_to_out, s1_valid_q && out_adv |=> out_valid_q)

endmodule

FILE: sv/fvr_angle.sv
// angle counter and sine/cosine lookup for the current frame
// depends on fvr_pkg and the assertion macro header
`include "frame_vertex_rotator_core_assert.svh"

module fvr_angle
  import fvr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  output trig_t cos_o,
  output trig_t sin_o
);

  localparam logic [AngleWidth-1:0] LastAngle = AngleWidth'(DegreesPerTurn - 1);

  logic [AngleWidth-1:0] angle_q;
  logic [AngleWidth-1:0] angle_d;

  // step one degree per finished frame, wrapping after a full turn
  always_comb begin
    angle_d = angle_q;
    if (advance_i) begin
      angle_d = (angle_q == LastAngle) ? '0 : angle_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else begin
      angle_q <= angle_d;
    end
  end

  // constant table lookup for the angle in force
  assign cos_o = trig_t'(CosTab[angle_q]);
  assign sin_o = trig_t'(SinTab[angle_q]);

  `FVR_ASSERT_ALWAYS(a_angle_in_range, !rst_ni || angle_q <= LastAngle)
  `FVR_ASSERT(a_angle_holds, !advance_i |=> $stable(angle_q))
  `FVR_ASSERT(a_angle_wraps, advance_i && angle_q == LastAngle |=> angle_q == '0)

endmodule

FILE: sv/fvr_rot_math.sv
// rotation datapath: four products, two sums, rounding and saturation
// depends on fvr_pkg
module fvr_rot_math
  import fvr_pkg::*;
(
  input  coord_t x_i,
  input  coord_t y_i,
  input  trig_t  cos_i,
  input  trig_t  sin_i,
  output coord_t x_rot_o,
  output coord_t y_rot_o
);

  localparam logic signed [ShiftWidth-1:0] MaxCoord =
    ShiftWidth'(2 ** (CoordWidth - 1) - 1);
  localparam logic signed [ShiftWidth-1:0] MinCoord =
    ShiftWidth'(-(2 ** (CoordWidth - 1)));
  localparam logic signed [SumWidth-1:0] Half = SumWidth'(2 ** (TrigFracBits - 1));

  // round to nearest with ties upward, then clamp to the coordinate range
  function automatic coord_t round_sat(input logic signed [SumWidth-1:0] acc);
    logic signed [SumWidth-1:0]   biased;
    logic signed [ShiftWidth-1:0] q;
    biased = acc + Half;
    q      = ShiftWidth'(biased >>> TrigFracBits);
    if (q > MaxCoord) begin
      return coord_t'(MaxCoord);
    end else if (q < MinCoord) begin
      return coord_t'(MinCoord);
    end
    return coord_t'(q);
  endfunction

  logic signed [ProdWidth-1:0] cx;
  logic signed [ProdWidth-1:0] sy;
  logic signed [ProdWidth-1:0] sx;
  logic signed [ProdWidth-1:0] cy;
  logic signed [SumWidth-1:0]  x_acc;
  logic signed [SumWidth-1:0]  y_acc;

  // independent products
  assign cx = ProdWidth'(cos_i) * ProdWidth'(x_i);
  assign sy = ProdWidth'(sin_i) * ProdWidth'(y_i);
  assign sx = ProdWidth'(sin_i) * ProdWidth'(x_i);
  assign cy = ProdWidth'(cos_i) * ProdWidth'(y_i);

  // full-precision sums
  assign x_acc = SumWidth'(cx) - SumWidth'(sy);
  assign y_acc = SumWidth'(sx) + SumWidth'(cy);

  assign x_rot_o = round_sat(x_acc);
  assign y_rot_o = round_sat(y_acc);

endmodule

FILE: test/frame_vertex_rotator_core_tb.sv
// self-checking testbench for frame_vertex_rotator_core: streams vertices with random
// idling on both channels and checks every rotated word against a local model
// depends on fvr_pkg for the coordinate type and trig constants, and on the rotator top level
module frame_vertex_rotator_core_tb;
  import fvr_pkg::*;

  localparam int      RandomWords = 1930;
  localparam int      TailWords   = 200;
  localparam int      HoldAfter   = 500;
  localparam int      HoldCycles  = 80;
  // 3.1416 / 180 as a ratio of integers
  localparam longint  RadNumer    = 3927;
  localparam longint  RadDenom    = 225000;
  localparam int      SeriesFrac  = 32;
  localparam int      SeriesShift = SeriesFrac - TrigFracBits;
  localparam coord_t  CoordMax    = 16'sh7fff;
  localparam coord_t  CoordMin    = 16'sh8000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   frame_end;
  } vertex_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  coord_t x_in_i      = '0;
  coord_t y_in_i      = '0;
  coord_t z_in_i      = '0;
  logic   frame_end_i = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  coord_t x_out_o;
  coord_t y_out_o;
  coord_t z_out_o;
  logic   frame_end_out_o;

  int      sin_q14 [DegreesPerTurn];
  int      cos_q14 [DegreesPerTurn];
  vertex_t vertex_q [$];
  vertex_t rotated_q [$];
  vertex_t in_word;
  int      total_words;
  int      words_taken;
  int      frame_ends;
  int      angle_deg;
  int      angle_wraps;
  int      input_stall_cycles;
  int      tx_gap;
  int      tx_idle_pct;
  int      rx_gap;
  int      rx_idle_pct;
  int      rx_count;
  int      hold_left;
  bit      hold_done;
  int      results_checked;
  int      mismatches;

  frame_vertex_rotator_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .x_in_i          (x_in_i),
    .y_in_i          (y_in_i),
    .z_in_i          (z_in_i),
    .frame_end_i     (frame_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .x_out_o         (x_out_o),
    .y_out_o         (y_out_o),
    .z_out_o         (z_out_o),
    .frame_end_out_o (frame_end_out_o)
  );

  // q32 series value to trig format, ties away from zero
  function automatic int q32_to_trig(longint signed v);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (SeriesShift - 1))) >> SeriesShift;
    return (v < 0) ? -int'(mag) : int'(mag);
  endfunction

  // divide by the trig scale, round half up, clamp to 16 bits
  function automatic coord_t round_clamp(longint signed acc);
    longint signed q;
    q = (acc + (longint'(1) <<< (TrigFracBits - 1))) >>> TrigFracBits;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return coord_t'(q);
  endfunction

  // rotate one vertex about z by a whole-degree angle
  function automatic vertex_t rotate_vertex(vertex_t v, int deg);
    longint signed cs;
    longint signed sn;
    longint signed vx;
    longint signed vy;
    vertex_t       r;
    cs = cos_q14[deg];
    sn = sin_q14[deg];
    vx = longint'($signed(v.x));
    vy = longint'($signed(v.y));
    r.x         = round_clamp(cs * vx - sn * vy);
    r.y         = round_clamp(sn * vx + cs * vy);
    r.z         = v.z;
    r.frame_end = v.frame_end;
    return r;
  endfunction

  // mostly full-range values, with the corners showing up often
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 11))
      0:       return CoordMax;
      1:       return CoordMin;
      2:       return coord_t'(0);
      3:       return coord_t'(-1);
      default: return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_vertex(coord_t x, coord_t y, coord_t z, logic fe);
    vertex_t w;
    w = '{x: x, y: y, z: z, frame_end: fe};
    vertex_q.insert(vertex_q.size(), w);
  endtask

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // sender: offers queued words, idles in bursts, tracks the angle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_stall_o) input_stall_cycles++;
      if (in_valid_i && !in_stall_o) begin
        rotated_q.insert(rotated_q.size(), rotate_vertex(in_word, angle_deg));
        if (in_word.frame_end) begin
          frame_ends++;
          if (angle_deg == DegreesPerTurn - 1) angle_wraps++;
          angle_deg = (angle_deg + 1) % DegreesPerTurn;
        end
        words_taken++;
        if (words_taken % 128 == 0) begin
          case ($urandom_range(0, 2))
            0:       tx_idle_pct = 0;
            1:       tx_idle_pct = 12;
            default: tx_idle_pct = 35;
          endcase
        end
      end
      // next word once the current one is gone
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (vertex_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (vertex_q.size() > TailWords && $urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap = $urandom_range(1, 7) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_word = vertex_q.pop_front();
          in_valid_i  <= 1'b1;
          x_in_i      <= in_word.x;
          y_in_i      <= in_word.y;
          z_in_i      <= in_word.z;
          frame_end_i <= in_word.frame_end;
        end
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        rx_count++;
        if (rx_count % 150 == 0) begin
          case ($urandom_range(0, 2))
            0:       rx_idle_pct = 0;
            1:       rx_idle_pct = 15;
            default: rx_idle_pct = 40;
          endcase
        end
      end
      if (!hold_done && rx_count >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else if (rx_count < total_words - TailWords
                   && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(1, 7) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rotated_q.size() == 0) begin
        $error("unexpected result word: x_out %0d y_out %0d", x_out_o, y_out_o);
        mismatches++;
      end else begin
        want = rotated_q.pop_front();
        results_checked++;
        if (x_out_o !== want.x) begin
          $error("x_out mismatch: expected %0d, got %0d", $signed(want.x), x_out_o);
          mismatches++;
        end
        if (y_out_o !== want.y) begin
          $error("y_out mismatch: expected %0d, got %0d", $signed(want.y), y_out_o);
          mismatches++;
        end
        if (z_out_o !== want.z) begin
          $error("z_out mismatch: expected %0d, got %0d", $signed(want.z), z_out_o);
          mismatches++;
        end
        if (frame_end_out_o !== want.frame_end) begin
          $error("frame_end_out mismatch: expected %0d, got %0d", want.frame_end,
                 frame_end_out_o);
          mismatches++;
        end
      end
    end
  end

  // timeout
  initial begin
    #4000000;
    $display("frame_vertex_rotator_core regression: fail");
    $finish;
  end

  // tables, stimulus, reset and end of run
  initial begin
    bit [63:0] arg;
    bit [63:0] term;
    bit [63:0] sin_pos;
    bit [63:0] sin_neg;
    bit [63:0] cos_pos;
    bit [63:0] cos_neg;
    int        frame_len;

    // sine and cosine per degree from taylor sums in q32
    for (int deg = 0; deg < DegreesPerTurn; deg++) begin
      arg     = 64'(deg) * 64'(RadNumer);
      term    = 64'd1 << SeriesFrac;
      sin_pos = '0;
      sin_neg = '0;
      cos_pos = term;
      cos_neg = '0;
      for (int k = 1; k < 100 && term != 0; k++) begin
        term = term * arg / 64'(RadDenom);
        term = term / 64'(k);
        case (k % 4)
          0:       cos_pos += term;
          1:       sin_pos += term;
          2:       cos_neg += term;
          default: sin_neg += term;
        endcase
      end
      sin_q14[deg] = q32_to_trig(longint'(sin_pos) - longint'(sin_neg));
      cos_q14[deg] = q32_to_trig(longint'(cos_pos) - longint'(cos_neg));
    end

    // directed: corners at zero degrees
    queue_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
    queue_vertex(CoordMax, CoordMax, CoordMax, 1'b0);
    queue_vertex(CoordMin, CoordMin, CoordMin, 1'b0);
    queue_vertex(CoordMax, CoordMin, coord_t'(1), 1'b0);
    queue_vertex(CoordMin, CoordMax, coord_t'(-1), 1'b0);
    queue_vertex(coord_t'(1), coord_t'(-1), coord_t'(16'h5555), 1'b1);
    // small angles where the corners saturate
    queue_vertex(CoordMax, CoordMin, coord_t'(16'haaaa), 1'b1);
    queue_vertex(CoordMin, CoordMax, coord_t'(0), 1'b0);
    queue_vertex(CoordMin, CoordMin, coord_t'(0), 1'b1);
    queue_vertex(CoordMax, CoordMax, CoordMin, 1'b1);
    queue_vertex(CoordMax, coord_t'(0), CoordMax, 1'b0);
    queue_vertex(coord_t'(0), CoordMin, coord_t'(0), 1'b0);
    // back-to-back single-vertex frames
    queue_vertex(coord_t'(16'h1234), coord_t'(-16'sh4321), coord_t'(7), 1'b1);
    queue_vertex(coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b1);
    queue_vertex(coord_t'(1), coord_t'(1), coord_t'(1), 1'b1);
    queue_vertex(coord_t'(16'h7ff0), coord_t'(16'h000f), coord_t'(16'h0f0f), 1'b1);
    queue_vertex(coord_t'(16'h8001), coord_t'(16'h7ffe), coord_t'(16'hf0f0), 1'b1);
    queue_vertex(coord_t'(3), coord_t'(-3), coord_t'(0), 1'b0);

    // random frames, mostly short so the angle turns past a full circle
    total_words = vertex_q.size() + RandomWords;
    while (vertex_q.size() < total_words) begin
      frame_len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (int i = 0; i < frame_len; i++) begin
        queue_vertex(rand_coord(), rand_coord(), rand_coord(), i == frame_len - 1);
      end
    end
    total_words = vertex_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken < total_words) @(posedge clk_i);
    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("rotated %0d vertices over %0d frames, angle wrapped %0d time(s)",
             results_checked, frame_ends, angle_wraps);
    $display("input held off for %0d cycles, %0d mismatch(es)", input_stall_cycles,
             mismatches);
    if (mismatches == 0) begin
      $display("frame_vertex_rotator_core regression: pass");
    end else begin
      $display("frame_vertex_rotator_core regression: fail");
    end
    $finish;
  end

endmodule
